// ----- rtl/cwms_pkg.sv -----
// Shared types and constants for the column-wrapped marquee scroller.
// No dependencies; imported by every module of the block.
package cwms_pkg;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STEP   = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  localparam logic [2:0] REG_CELL_COUNT     = 3'd0;
  localparam logic [2:0] REG_START_ROW      = 3'd1;
  localparam logic [2:0] REG_START_COL      = 3'd2;
  localparam logic [2:0] REG_WRAP_FIRST_ROW = 3'd3;
  localparam logic [2:0] REG_WRAP_LAST_ROW  = 3'd4;

  localparam logic [7:0] PAD_CHAR = 8'h20;

  // Result queue depth and the width of its fill level.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_LVL_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_STEP,
    CMD_RENDER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] char_code;
    logic [7:0] char_index;
    logic       text_last;
    logic       step_dir;
  } cmd_t;

  typedef struct packed {
    logic [6:0] cell_count;
    logic [7:0] start_row;
    logic [7:0] start_col;
    logic [7:0] wrap_first_row;
    logic [7:0] wrap_last_row;
  } cfg_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_row;
    logic [8:0] cell_col;
    logic       cell_last;
  } cell_t;

endpackage

// ----- rtl/cwms_front.sv -----
// Front end: decodes incoming items into commands and holds them in a
// two-entry command queue. Depends on cwms_pkg.
module cwms_front
  import cwms_pkg::*;
#(
  parameter int TEXT_MAX = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] operation,
  input  logic [7:0] char_code,
  input  logic [7:0] char_index,
  input  logic       text_last,
  input  logic       step_dir,
  output logic       cmd_valid,
  output cmd_t       cmd_head,
  input  logic       cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  logic       keep;
  cmd_t       cmd_new;

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_head  = q_r[rd_ptr_r];
  assign accept    = push && !full;

  // Unused opcode and loads past the end of the store do nothing.
  always_comb begin
    cmd_new.char_code  = char_code;
    cmd_new.char_index = char_index;
    cmd_new.text_last  = text_last;
    cmd_new.step_dir   = step_dir;
    keep               = 1'b1;
    case (operation)
      OP_LOAD: begin
        cmd_new.kind = CMD_LOAD;
        keep         = (32'(char_index) < TEXT_MAX);
      end
      OP_STEP:   cmd_new.kind = CMD_STEP;
      OP_RENDER: cmd_new.kind = CMD_RENDER;
      default: begin
        cmd_new.kind = CMD_STEP;
        keep         = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept && keep) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    cnt_nxt = cnt_r + 2'(accept && keep) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

// ----- rtl/cwms_ofifo.sv -----
// Result queue between the render engine and the output ports.
// Depends on cwms_pkg.
module cwms_ofifo
  import cwms_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  cell_t               wr_data,
  input  logic                rd,
  output logic                empty,
  output cell_t               head,
  output logic [OQ_LVL_W-1:0] level
);

  localparam int PW = $clog2(OQ_DEPTH);

  cell_t                mem [OQ_DEPTH];
  logic [PW-1:0]        wr_ptr_r;
  logic [PW-1:0]        rd_ptr_r;
  logic [OQ_LVL_W-1:0]  lvl_r;
  logic                 do_rd;

  assign empty = (lvl_r == '0);
  assign level = lvl_r;
  assign head  = mem[rd_ptr_r];
  assign do_rd = rd && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      lvl_r <= lvl_r + OQ_LVL_W'(wr) - OQ_LVL_W'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> (lvl_r < OQ_LVL_W'(OQ_DEPTH)))
    else $error("result queue written while full");

endmodule

// ----- rtl/cwms_back.sv -----
// Back end: executes load, step and render commands. Owns the text store,
// the length, the scroll shift, the remainder unit and the cell sequencer.
// Depends on cwms_pkg; feeds cwms_ofifo.
module cwms_back
  import cwms_pkg::*;
#(
  parameter int TEXT_MAX  = 256,
  parameter int MAX_CELLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                cmd_valid,
  input  cmd_t                cmd_head,
  output logic                cmd_pop,
  input  logic [OQ_LVL_W-1:0] oq_level,
  output logic                oq_wr,
  output cell_t               oq_data
);

  // Only the first 256 entries are reachable through an 8-bit index.
  localparam int DEPTH = (TEXT_MAX < 256) ? TEXT_MAX : 256;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [6:0] MAX_CELLS_7 = 7'(MAX_CELLS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CELLS
  } state_t;

  logic [7:0]  text_mem [DEPTH];
  logic [7:0]  rdata_r;

  state_t      state_r;
  logic [8:0]  len_r;
  logic [31:0] shift_r;
  logic [8:0]  mod_r;
  logic [31:0] dvd_r;
  logic [8:0]  rem_r;
  logic        neg_r;
  logic [4:0]  bit_cnt_r;
  logic [8:0]  idx_r;
  logic [5:0]  cnt_r;
  logic [6:0]  cells_r;
  logic [7:0]  row_r;
  logic [8:0]  col_r;
  logic        rd_valid_r;
  logic        pad_r;
  logic [7:0]  orow_r;
  logic [8:0]  ocol_r;
  logic        olast_r;

  logic [6:0]  cells_eff;
  logic [31:0] shift_mag;
  logic [9:0]  trial;
  logic [8:0]  rem_step;
  logic [8:0]  idx_start;
  logic        issue;
  logic        last_cell;
  logic [8:0]  idx_inc;
  logic [8:0]  row_inc;

  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign cells_eff = (cfg.cell_count > MAX_CELLS_7) ? MAX_CELLS_7 : cfg.cell_count;
  assign shift_mag = shift_r[31] ? (~shift_r + 32'd1) : shift_r;

  // One restoring step of |shift| mod M per cycle.
  assign trial    = {rem_r, dvd_r[31]};
  assign rem_step = (trial >= {1'b0, mod_r}) ? 9'(trial - {1'b0, mod_r}) : trial[8:0];
  // Floored modulo of the negated shift.
  assign idx_start = (neg_r && rem_step != 9'd0) ? (mod_r - rem_step) : rem_step;

  // Keep one slot for the read that is still in flight.
  assign issue     = (state_r == S_CELLS) &&
                     ((oq_level + OQ_LVL_W'(rd_valid_r)) < OQ_LVL_W'(OQ_DEPTH));
  assign last_cell = ({1'b0, cnt_r} + 7'd1) == cells_r;
  assign idx_inc   = ((idx_r + 9'd1) == mod_r) ? 9'd0 : (idx_r + 9'd1);
  assign row_inc   = {1'b0, row_r} + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_r      <= 9'd0;
      shift_r    <= 32'd0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd_head.kind)
              CMD_LOAD: begin
                if (cmd_head.text_last) begin
                  len_r <= {1'b0, cmd_head.char_index} + 9'd1;
                end
              end
              CMD_STEP: begin
                shift_r <= cmd_head.step_dir ? (shift_r - 32'd1) : (shift_r + 32'd1);
              end
              CMD_RENDER: begin
                if (cells_eff != 7'd0) begin
                  cells_r   <= cells_eff;
                  mod_r     <= (len_r < {2'b00, cells_eff}) ? {2'b00, cells_eff} : len_r;
                  dvd_r     <= shift_mag;
                  neg_r     <= !shift_r[31] && (shift_r != 32'd0);
                  rem_r     <= 9'd0;
                  bit_cnt_r <= 5'd0;
                  state_r   <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          rem_r     <= rem_step;
          dvd_r     <= {dvd_r[30:0], 1'b0};
          bit_cnt_r <= bit_cnt_r + 5'd1;
          if (bit_cnt_r == 5'd31) begin
            idx_r   <= idx_start;
            cnt_r   <= 6'd0;
            row_r   <= cfg.start_row;
            col_r   <= {1'b0, cfg.start_col};
            state_r <= S_CELLS;
          end
        end
        S_CELLS: begin
          if (issue) begin
            rd_valid_r <= 1'b1;
            pad_r      <= (idx_r >= len_r);
            orow_r     <= row_r;
            ocol_r     <= col_r;
            olast_r    <= last_cell;
            idx_r      <= idx_inc;
            cnt_r      <= cnt_r + 6'd1;
            if (row_inc > {1'b0, cfg.wrap_last_row}) begin
              row_r <= cfg.wrap_first_row;
              col_r <= col_r + 9'd1;
            end else begin
              row_r <= row_inc[7:0];
            end
            if (last_cell) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_head.kind == CMD_LOAD) begin
      text_mem[cmd_head.char_index[AW-1:0]] <= cmd_head.char_code;
    end
    if (issue) begin
      rdata_r <= text_mem[idx_r[AW-1:0]];
    end
  end

  assign oq_wr             = rd_valid_r;
  assign oq_data.cell_char = pad_r ? PAD_CHAR : rdata_r;
  assign oq_data.cell_row  = orow_r;
  assign oq_data.cell_col  = ocol_r;
  assign oq_data.cell_last = olast_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CELLS) |-> (idx_r < mod_r))
    else $error("text index outside modulus");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && last_cell) |=> (state_r == S_IDLE && rd_valid_r && olast_r))
    else $error("final cell did not close the frame");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd_pop)
    else $error("command taken while busy");

endmodule

// ----- rtl/column_wrapped_marquee_scroller.sv -----
// Column-wrapped scrolling text marquee: top level with configuration registers.
// Depends on cwms_pkg, cwms_front, cwms_back and cwms_ofifo.
//
// Items enter through a queue-like port (push/full) and are decoded into a
// two-entry command queue; a back end takes one command at a time. A load
// writes one character into the text store (and sets the length when marked
// last) and a step moves the 32-bit scroll shift by one. A render first works
// out the floored remainder of the negated shift by the text modulus (the cell
// count when the text is shorter, else the text length) on a shift-subtract
// unit, one bit per cycle, then emits one cell per cycle while the four-entry
// result queue has room. Cells are drawn down a column from start_row/start_col;
// a row past wrap_last_row goes back to wrap_first_row in the next column.
// Cells beyond the text show a space.
// Results are read through empty/pop; an item is taken while earlier results
// still wait. Text entries never loaded read back as unknown characters.
// Registers are written by cfg_we/cfg_index/cfg_wdata and should only change
// while the block is idle.
module column_wrapped_marquee_scroller
  import cwms_pkg::*;
#(
  parameter int TEXT_MAX  = 256,
  parameter int MAX_CELLS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // item input
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_char_index,
  input  logic       in_text_last,
  input  logic       in_step_dir,
  // result output
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_row,
  output logic [8:0] out_cell_col,
  output logic       out_cell_last,
  // configuration
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  cfg_t                cfg_r;
  logic                cmd_valid;
  cmd_t                cmd_head;
  logic                cmd_pop;
  logic [OQ_LVL_W-1:0] oq_level;
  logic                oq_wr;
  cell_t               oq_data;
  cell_t               oq_head;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_count     <= 7'd64;
      cfg_r.start_row      <= 8'd1;
      cfg_r.start_col      <= 8'd0;
      cfg_r.wrap_first_row <= 8'd1;
      cfg_r.wrap_last_row  <= 8'd40;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_COUNT:     cfg_r.cell_count     <= cfg_wdata[6:0];
        REG_START_ROW:      cfg_r.start_row      <= cfg_wdata;
        REG_START_COL:      cfg_r.start_col      <= cfg_wdata;
        REG_WRAP_FIRST_ROW: cfg_r.wrap_first_row <= cfg_wdata;
        REG_WRAP_LAST_ROW:  cfg_r.wrap_last_row  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cwms_front #(
    .TEXT_MAX (TEXT_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .operation  (in_operation),
    .char_code  (in_char_code),
    .char_index (in_char_index),
    .text_last  (in_text_last),
    .step_dir   (in_step_dir),
    .cmd_valid  (cmd_valid),
    .cmd_head   (cmd_head),
    .cmd_pop    (cmd_pop)
  );

  cwms_back #(
    .TEXT_MAX  (TEXT_MAX),
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .oq_level  (oq_level),
    .oq_wr     (oq_wr),
    .oq_data   (oq_data)
  );

  cwms_ofifo u_ofifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (oq_wr),
    .wr_data (oq_data),
    .rd      (pop),
    .empty   (empty),
    .head    (oq_head),
    .level   (oq_level)
  );

  assign out_cell_char = oq_head.cell_char;
  assign out_cell_row  = oq_head.cell_row;
  assign out_cell_col  = oq_head.cell_col;
  assign out_cell_last = oq_head.cell_last;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for column_wrapped_marquee_scroller.
// Depends on cwms_pkg and the block's RTL. An in-bench predictor works out
// every expected cell, and the cells are compared in order.
`timescale 1ns / 100ps

module tb_top;
  import cwms_pkg::*;

  // Operation code 3 is unused by the block and must be swallowed silently.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Settling time that covers any item still in flight once the last expected
  // cell has gone.
  localparam int SETTLE_CYCLES  = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int NUM_SCRIPT     = 20;
  localparam int NUM_PHASES     = 7;
  localparam int MAX_REPORTS    = 30;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] code;
    logic [7:0] pos;
    logic       last;
    logic       dir;
  } marquee_item_t;

  // One row of the opening script. Where typed is set, the final cell of the
  // frame is given by hand and replaces the predicted one.
  typedef struct packed {
    marquee_item_t item;
    logic          typed;
    cell_t         final_cell;
  } script_row_t;

  // Register settings for one phase, how both sides idle during it, and its squeeze, long-text and budget choices.
  typedef struct {
    logic [7:0] count_wr;
    logic [7:0] srow;
    logic [7:0] scol;
    logic [7:0] wfirst;
    logic [7:0] wlast;
    int         send_idle;
    int         recv_stall;
    bit         squeeze;
    bit         long_text;
    int         budget;
  } phase_t;

  // ---------------------------------------------------------------------------
  // Block ports. Every input holds a known value from time zero.
  // ---------------------------------------------------------------------------
  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       push          = 1'b0;
  logic [1:0] in_operation  = OP_LOAD;
  logic [7:0] in_char_code  = 8'h00;
  logic [7:0] in_char_index = 8'h00;
  logic       in_text_last  = 1'b0;
  logic       in_step_dir   = 1'b0;
  logic       pop           = 1'b0;
  logic       cfg_we        = 1'b0;
  logic [2:0] cfg_index     = REG_CELL_COUNT;
  logic [7:0] cfg_wdata     = 8'h00;
  logic       full;
  logic       empty;
  logic [7:0] out_cell_char;
  logic [7:0] out_cell_row;
  logic [8:0] out_cell_col;
  logic       out_cell_last;

  column_wrapped_marquee_scroller dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_operation  (in_operation),
    .in_char_code  (in_char_code),
    .in_char_index (in_char_index),
    .in_text_last  (in_text_last),
    .in_step_dir   (in_step_dir),
    .empty         (empty),
    .pop           (pop),
    .out_cell_char (out_cell_char),
    .out_cell_row  (out_cell_row),
    .out_cell_col  (out_cell_col),
    .out_cell_last (out_cell_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the text, length, shift and registers.
  // text_written tracks which entries hold a real character, so that no
  // render is ever asked to show an entry that was never loaded.
  // ---------------------------------------------------------------------------
  logic [7:0] text_mem [256];
  bit         text_written [256];
  logic [8:0] text_len = 9'd0;
  logic [31:0] scroll  = 32'd0;
  cfg_t       regs     = '{7'd64, 8'd1, 8'd0, 8'd1, 8'd40};
  cell_t      pending_cells [$];

  int err_count      = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;

  // Opening script, run on the reset settings (64 cells from row 1, column 0,
  // rows 1 to 40). An empty text shows spaces only, and 64 cells end on
  // row 24 of column 1 whatever the shift.
  script_row_t script [NUM_SCRIPT] = '{
    '{'{OP_RENDER, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, '{PAD_CHAR, 8'd24, 9'd1, 1'b1}},
    '{'{OP_SPARE,  8'hFF, 8'hFF, 1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_STEP,   8'h55, 8'hAA, 1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_RENDER, 8'hFF, 8'hFF, 1'b1, 1'b1}, 1'b1, '{PAD_CHAR, 8'd24, 9'd1, 1'b1}},
    '{'{OP_STEP,   8'hAA, 8'h55, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD,   8'h00, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
    '{'{OP_LOAD,   8'hFF, 8'h01, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD,   8'h41, 8'h02, 1'b1, 1'b0}, 1'b0, '0},
    '{'{OP_RENDER, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_STEP,   8'h00, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
    '{'{OP_STEP,   8'hFF, 8'hFF, 1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_RENDER, 8'h12, 8'h34, 1'b1, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD,   8'h7E, 8'hFF, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_SPARE,  8'h00, 8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_STEP,   8'h01, 8'h80, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_STEP,   8'h80, 8'h01, 1'b1, 1'b0}, 1'b0, '0},
    '{'{OP_STEP,   8'h3C, 8'hC3, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_RENDER, 8'h00, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
    '{'{OP_LOAD,   8'h42, 8'h03, 1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_RENDER, 8'hC3, 8'h3C, 1'b0, 1'b0}, 1'b0, '0}
  };

  // Phases: extremes of every register, cell counts of zero and above the
  // maximum, a start row beneath the last row and a return row above it.
  phase_t phases [NUM_PHASES] = '{
    '{8'h01, 8'd255, 8'd255, 8'd0,   8'd255, 70, 0,  1'b0, 1'b0, 8},
    '{8'h00, 8'd0,   8'd0,   8'd0,   8'd0,   22, 22, 1'b0, 1'b0, 6},
    '{8'hFF, 8'd200, 8'd100, 8'd5,   8'd10,  0,  70, 1'b0, 1'b0, 8},
    '{8'h0C, 8'd3,   8'd0,   8'd9,   8'd4,   22, 22, 1'b0, 1'b0, 8},
    '{8'h40, 8'd0,   8'd255, 8'd0,   8'd0,   0,  0,  1'b1, 1'b0, 8},
    '{8'h10, 8'd1,   8'd17,  8'd1,   8'd40,  70, 0,  1'b0, 1'b1, 8},
    '{8'h41, 8'd7,   8'd8,   8'd255, 8'd30,  0,  70, 1'b0, 1'b0, 8}
  };

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void set_reg(logic [2:0] idx, logic [7:0] val);
    case (idx)
      REG_CELL_COUNT:     regs.cell_count     = val[6:0];
      REG_START_ROW:      regs.start_row      = val;
      REG_START_COL:      regs.start_col      = val;
      REG_WRAP_FIRST_ROW: regs.wrap_first_row = val;
      REG_WRAP_LAST_ROW:  regs.wrap_last_row  = val;
      default: ;
    endcase
  endfunction

  // Builds one frame and queues its cells. A text shorter than the frame is
  // rotated inside a space-padded field; a longer one is windowed cyclically.
  // Both use a floored remainder of the signed shift.
  function automatic void draw_frame();
    logic [7:0] frame [64];
    int         cells;
    int         n;
    int         i;
    int         r;
    int         c;
    longint     sh;
    longint     p;
    cell_t      cl;
    cells = (regs.cell_count > 7'd64) ? 64 : int'(regs.cell_count);
    if (cells == 0) return;
    n  = int'(text_len);
    sh = longint'($signed(scroll));
    for (i = 0; i < cells; i++) begin
      if (n < cells) begin
        p = (i + sh) % cells;
        if (p < 0) p += cells;
        frame[p] = (i < n) ? text_mem[i] : PAD_CHAR;
      end else begin
        p = (i - sh) % n;
        if (p < 0) p += n;
        frame[i] = text_mem[p];
      end
    end
    // Down the column; past the last row, back to the return row one column on.
    r = int'(regs.start_row);
    c = int'(regs.start_col);
    for (i = 0; i < cells; i++) begin
      cl.cell_char = frame[i];
      cl.cell_row  = r[7:0];
      cl.cell_col  = c[8:0];
      cl.cell_last = (i == cells - 1);
      pending_cells.push_back(cl);
      r++;
      if (r > int'(regs.wrap_last_row)) begin
        r = int'(regs.wrap_first_row);
        c++;
      end
    end
  endfunction

  function automatic void advance_marquee(marquee_item_t it);
    case (it.op)
      OP_LOAD: begin
        text_mem[it.pos]     = it.code;
        text_written[it.pos] = 1'b1;
        if (it.last) text_len = {1'b0, it.pos} + 9'd1;
      end
      OP_STEP:   scroll = it.dir ? scroll - 32'd1 : scroll + 32'd1;
      OP_RENDER: draw_frame();
      default: ;
    endcase
  endfunction

  // True when every entry below upto holds a loaded character.
  function automatic bit prefix_loaded(int upto);
    int k;
    for (k = 0; k < upto; k++)
      if (!text_written[k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic marquee_item_t rand_item(logic [1:0] op);
    marquee_item_t it;
    it.op   = op;
    it.code = 8'($urandom_range(255));
    it.pos  = 8'($urandom_range(255));
    it.last = 1'($urandom_range(1));
    it.dir  = 1'($urandom_range(1));
    return it;
  endfunction

  // Mostly short texts; some long enough to window a full frame.
  function automatic int pick_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return $urandom_range(1, 20);
    return $urandom_range(21, 80);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus tasks. All are entered just after a rising edge. push is never
  // lowered and raised within one time step: it is lowered only for an idle
  // cycle, which always ends on the next edge, or while draining.
  // ---------------------------------------------------------------------------
  task automatic send_item(marquee_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    in_operation  <= it.op;
    in_char_code  <= it.code;
    in_char_index <= it.pos;
    in_text_last  <= it.last;
    in_step_dir   <= it.dir;
    @(posedge clk);
    while (full) @(posedge clk);
    advance_marquee(it);
    items_sent++;
  endtask

  // Loads a text of length len: every entry not yet loaded, a few rewrites,
  // and always the final entry with its last flag.
  task automatic send_text(int len);
    marquee_item_t it;
    int            k;
    for (k = 0; k < len; k++) begin
      if (!text_written[k] || k == len - 1 || $urandom_range(7) == 0) begin
        it      = rand_item(OP_LOAD);
        it.pos  = 8'(k);
        it.last = (k == len - 1);
        send_item(it);
      end
    end
  endtask

  // Stops offering items until every expected cell has arrived, then lets
  // the block settle so that nothing is in flight.
  task automatic drain();
    push <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(phase_t ph);
    logic [2:0] idx [5];
    logic [7:0] val [5];
    int         k;
    idx = '{REG_CELL_COUNT, REG_START_ROW, REG_START_COL,
            REG_WRAP_FIRST_ROW, REG_WRAP_LAST_ROW};
    val = '{ph.count_wr, ph.srow, ph.scol, ph.wfirst, ph.wlast};
    cfg_we <= 1'b1;
    for (k = 0; k < 5; k++) begin
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      set_reg(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // Random traffic: mostly text-steps-render sequences with random content,
  // the rest single items of any operation.
  task automatic run_phase(phase_t ph);
    marquee_item_t it;
    int            start;
    int            n;
    logic          d;
    logic [1:0]    pick;
    start = items_sent;
    if (ph.squeeze) begin
      // Receiver holds off while full frames keep coming: fills the block.
      hold_req = 1'b1;
      repeat (4) send_item(rand_item(OP_RENDER));
    end
    if (ph.long_text) send_text(80);
    while (items_sent - start < ph.budget) begin
      if ($urandom_range(99) < 75) begin
        if (text_len == 9'd0 || $urandom_range(2) == 0) send_text(pick_len());
        n = $urandom_range(8);
        d = 1'($urandom_range(1));
        repeat (n) begin
          it = rand_item(OP_STEP);
          if ($urandom_range(4) != 0) it.dir = d;
          send_item(it);
        end
        repeat ($urandom_range(1, 2)) send_item(rand_item(OP_RENDER));
      end else begin
        pick = 2'($urandom_range(3));
        it   = rand_item(pick);
        // A length may only cover entries that hold loaded characters.
        if (it.op == OP_LOAD && !prefix_loaded(int'(it.pos))) it.last = 1'b0;
        send_item(it);
      end
    end
  endtask

  function automatic void check_field(string what, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Result side: checks each accepted cell against the oldest expectation,
  // then picks pop for the next cycle. A hold request from the stimulus side
  // keeps pop low; the length of the hold is counted here.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    cell_t want;
    int    hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (pending_cells.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: unexpected cell, expected none, actual %h/%h/%h/%b", $time,
                     out_cell_char, out_cell_row, out_cell_col, out_cell_last);
        end else begin
          want = pending_cells.pop_front();
          check_field("cell_char", 9'(want.cell_char), 9'(out_cell_char));
          check_field("cell_row",  9'(want.cell_row),  9'(out_cell_row));
          check_field("cell_col",  want.cell_col,      out_cell_col);
          check_field("cell_last", 9'(want.cell_last), 9'(out_cell_last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too many cycles in a row with no handshake on any port.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, opening script on the reset settings, then one
  // random phase per register setting, each begun from an idle block.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Opening script, no idling on either side.
    for (r = 0; r < NUM_SCRIPT; r++) begin
      send_item(script[r].item);
      if (script[r].typed && pending_cells.size() != 0)
        pending_cells[pending_cells.size() - 1] = script[r].final_cell;
    end

    for (r = 0; r < NUM_PHASES; r++) begin
      drain();
      write_regs(phases[r]);
      send_idle_pct  = phases[r].send_idle;
      recv_stall_pct = phases[r].recv_stall;
      run_phase(phases[r]);
    end

    drain();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cwms_pkg.sv
rtl/cwms_front.sv
rtl/cwms_ofifo.sv
rtl/cwms_back.sv
rtl/column_wrapped_marquee_scroller.sv
sim/tb_top.sv
